@@ hw/rtl/ifbs_pkg.sv @@
// ifbs_pkg: shared types and constants of the info frame byte stuffer.
// No dependencies. Imported by every other RTL file in hw/rtl.
package ifbs_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // Register indexes on the configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_EVEN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_ODD  = 2'd2;

  localparam logic [7:0] ADDRESS_RESET      = 8'd3;
  localparam logic [7:0] CONTROL_EVEN_RESET = 8'd0;
  localparam logic [7:0] CONTROL_ODD_RESET  = 8'd64;

  // Fixed slots of one run:
  // 0..3 header, 4 data escape, 5 data, 6 check escape, 7 check, 8 closing flag
  localparam int NUM_SLOTS  = 9;
  localparam int SLOT_IDX_W = 4;
  localparam logic [SLOT_IDX_W-1:0] SLOT_HDR_FLAG  = 4'd0;
  localparam logic [SLOT_IDX_W-1:0] SLOT_HDR_ADDR  = 4'd1;
  localparam logic [SLOT_IDX_W-1:0] SLOT_HDR_CTRL  = 4'd2;
  localparam logic [SLOT_IDX_W-1:0] SLOT_HDR_BCC   = 4'd3;
  localparam logic [SLOT_IDX_W-1:0] SLOT_DATA_ESC  = 4'd4;
  localparam logic [SLOT_IDX_W-1:0] SLOT_DATA      = 4'd5;
  localparam logic [SLOT_IDX_W-1:0] SLOT_CHECK_ESC = 4'd6;
  localparam logic [SLOT_IDX_W-1:0] SLOT_CHECK     = 4'd7;
  localparam logic [SLOT_IDX_W-1:0] SLOT_END_FLAG  = 4'd8;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_run;
    logic       end_of_frame;
  } out_item_t;

  // One run of line bytes built from one input transaction
  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] bytes;
    logic [NUM_SLOTS-1:0]      mask;
  } run_t;

  // Load handshake between builder and serializer
  typedef struct packed {
    logic valid;
    run_t run;
  } run_load_t;

endpackage

@@ hw/rtl/info_frame_byte_stuffer.sv @@
// info_frame_byte_stuffer: top level of the information frame framer.
// Depends on ifbs_pkg, ifbs_frame_builder, ifbs_serializer.
//
// Usage:
//   in_*  : one payload byte per transaction (valid high, stall low), with
//           last_of_frame marking the final byte of a frame.
//   out_* : framed, stuffed line bytes, one per transaction. end_of_run
//           marks the last byte caused by one input transaction and
//           end_of_frame marks the closing flag.
//   cfg_* : register writes (address, control even, control odd); cfg_ready
//           is always high. Unknown indexes are ignored. Write while idle.
// A frame opens with flag, address, control, address XOR control; each
// payload byte and the closing XOR check byte are stuffed (0x7E/0x7D become
// 0x7D, byte XOR 0x20); the frame ends with a flag and the sequence bit
// toggles.
// An accepted input is written into the run buffer; its line bytes then move
// one by one into the output register, from which the output takes them.
// Throughput: one line byte per cycle on the output while out_stall is low;
// an input transaction occupies the run buffer until all of its line bytes
// (1 to 9) have moved to the output register, and the next one is accepted in
// the cycle its predecessor's last byte moves to the output register.
// Reset (rst, synchronous): registers return to their defaults, frame state
// and sequence bit clear, the buffered run and output are dropped.
// Output stall holds out_data; the run buffer then fills and in_stall rises.
module info_frame_byte_stuffer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ifbs_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ifbs_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ifbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                        cfg_data
);
  import ifbs_pkg::*;

  run_load_t load;
  logic      load_ready;

  // state, registers and per-transaction slot building
  ifbs_frame_builder u_builder (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .load_ready (load_ready),
    .load       (load)
  );

  // run buffer drained one byte per cycle into the output register, unless stalled
  ifbs_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ hw/rtl/ifbs_frame_builder.sv @@
// ifbs_frame_builder: frame state, config registers, and slot builder.
// Depends on ifbs_pkg.
module ifbs_frame_builder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ifbs_pkg::in_item_t                 in_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ifbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               load_ready,
  output ifbs_pkg::run_load_t                load
);
  import ifbs_pkg::*;

  logic [7:0] address_byte;
  logic [7:0] control_even;
  logic [7:0] control_odd;
  logic       inside_frame;
  logic [7:0] check_accumulator;
  logic       sequence_bit;

  logic       accept;
  logic [7:0] ctrl;
  logic [7:0] data;
  logic [7:0] check;
  logic       last;
  logic       data_esc;
  logic       check_esc;
  run_t       run;

  assign cfg_ready = 1'b1;
  assign in_stall  = !load_ready;
  assign accept    = in_valid && load_ready;

  always_comb begin
    data      = in_data.payload_byte;
    last      = in_data.last_of_frame;
    ctrl      = sequence_bit ? control_odd : control_even;
    // accumulator is logically zero at frame start
    check     = (inside_frame ? check_accumulator : 8'h00) ^ data;
    data_esc  = (data == FLAG_BYTE) || (data == ESC_BYTE);
    check_esc = (check == FLAG_BYTE) || (check == ESC_BYTE);

    run.bytes                 = '0;
    run.bytes[SLOT_HDR_FLAG]  = FLAG_BYTE;
    run.bytes[SLOT_HDR_ADDR]  = address_byte;
    run.bytes[SLOT_HDR_CTRL]  = ctrl;
    run.bytes[SLOT_HDR_BCC]   = address_byte ^ ctrl;
    run.bytes[SLOT_DATA_ESC]  = ESC_BYTE;
    run.bytes[SLOT_DATA]      = data_esc ? (data ^ ESC_XOR) : data;
    run.bytes[SLOT_CHECK_ESC] = ESC_BYTE;
    run.bytes[SLOT_CHECK]     = check_esc ? (check ^ ESC_XOR) : check;
    run.bytes[SLOT_END_FLAG]  = FLAG_BYTE;

    run.mask                 = '0;
    run.mask[SLOT_HDR_FLAG]  = !inside_frame;
    run.mask[SLOT_HDR_ADDR]  = !inside_frame;
    run.mask[SLOT_HDR_CTRL]  = !inside_frame;
    run.mask[SLOT_HDR_BCC]   = !inside_frame;
    run.mask[SLOT_DATA_ESC]  = data_esc;
    run.mask[SLOT_DATA]      = 1'b1;
    run.mask[SLOT_CHECK_ESC] = last && check_esc;
    run.mask[SLOT_CHECK]     = last;
    run.mask[SLOT_END_FLAG]  = last;

    load.valid = accept;
    load.run   = run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte      <= ADDRESS_RESET;
      control_even      <= CONTROL_EVEN_RESET;
      control_odd       <= CONTROL_ODD_RESET;
      inside_frame      <= 1'b0;
      check_accumulator <= 8'h00;
      sequence_bit      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ADDRESS:      address_byte <= cfg_data;
          REG_CONTROL_EVEN: control_even <= cfg_data;
          REG_CONTROL_ODD:  control_odd  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (last) begin
          inside_frame      <= 1'b0;
          check_accumulator <= 8'h00;
          sequence_bit      <= !sequence_bit;
        end else begin
          inside_frame      <= 1'b1;
          check_accumulator <= check;
        end
      end
    end
  end

endmodule

@@ hw/rtl/ifbs_serializer.sv @@
// ifbs_serializer: run buffer and output register, one line byte per cycle unless stalled.
// Depends on ifbs_pkg.
module ifbs_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  ifbs_pkg::run_load_t  load,
  output logic                 load_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ifbs_pkg::out_item_t  out_data
);
  import ifbs_pkg::*;

  logic [NUM_SLOTS-1:0][7:0] slot_bytes;
  logic [NUM_SLOTS-1:0]      mask;
  logic [NUM_SLOTS-1:0]      mask_next;

  logic                  advance;
  logic                  found;
  logic [SLOT_IDX_W-1:0] pick;
  logic [NUM_SLOTS-1:0]  mask_left;

  // lowest pending slot
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        found = 1'b1;
        pick  = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    advance   = found && (!out_valid || !out_stall);
    mask_left = mask;
    if (advance) begin
      mask_left[pick] = 1'b0;
    end
    load_ready = (mask_left == '0);
    mask_next  = load.valid ? load.run.mask : mask_left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      mask <= mask_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      slot_bytes <= load.run.bytes;
    end
    if (advance) begin
      out_data.line_byte    <= slot_bytes[pick];
      out_data.end_of_run   <= (mask_left == '0);
      out_data.end_of_frame <= (pick == SLOT_END_FLAG);
    end
  end

endmodule

@@ tb/tb_info_frame_byte_stuffer.sv @@
`timescale 1ns / 100ps
// tb_info_frame_byte_stuffer: self-checking testbench of the information frame
// byte stuffer. Predicts the header, stuffed payload, check byte and flags.
// Depends on ifbs_pkg and the info_frame_byte_stuffer RTL.
module tb_info_frame_byte_stuffer;
  import ifbs_pkg::*;

  localparam int LONG_HOLD_CYCLES = 300;  // receiver hold-off, fills the block
  localparam int PHASE_ITEMS      = 62;   // minimum count of random payload bytes queued per phase
  localparam int NUM_PHASES       = 4;
  localparam int SETTLE_CYCLES    = 20;   // quiet time after the last line byte
  localparam int WATCHDOG_NS      = 2_000_000;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // DUT ports, all inputs known from time zero
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data  = '0;

  // Predicted block state: registers, frame state, check XOR, sequence bit
  logic [7:0] pred_address;
  logic [7:0] pred_ctrl_even;
  logic [7:0] pred_ctrl_odd;
  logic       pred_in_frame;
  logic [7:0] pred_check;
  logic       pred_seq;

  in_item_t  payload_q[$];     // payload bytes not yet offered
  out_item_t line_byte_q[$];   // line bytes predicted, not yet seen

  int unsigned items_pushed = 0;
  int unsigned items_taken  = 0;
  int unsigned bytes_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned escapes_made  = 0;
  int unsigned mismatches    = 0;

  // Sender burst shaping (driver only)
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // Receiver stall pattern (stall process; long_hold_go is set by the main sequence)
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;
  int unsigned hold_left  = 0;
  logic        long_hold_go = 1'b0;

  out_item_t want;

  info_frame_byte_stuffer u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out every line byte one payload transaction produces and queue them.
  // Header values are taken now, so later register writes only hit later frames.
  task automatic predict_line_bytes(input in_item_t item);
    logic [7:0] run_byte [0:NUM_SLOTS-1];
    logic [7:0] ctrl;
    logic [7:0] raw;
    int         n;
    int         k;
    out_item_t  res;
    n = 0;
    if (!pred_in_frame) begin
      ctrl = pred_seq ? pred_ctrl_odd : pred_ctrl_even;
      run_byte[0] = FLAG_BYTE;
      run_byte[1] = pred_address;
      run_byte[2] = ctrl;
      run_byte[3] = pred_address ^ ctrl;   // header is never stuffed
      n = 4;
      pred_in_frame = 1'b1;
      pred_check    = '0;
    end
    pred_check = pred_check ^ item.payload_byte;
    // data byte first, then the check byte on the last one; both stuffed
    for (k = 0; k < 2; k++) begin
      if (k == 0 || item.last_of_frame) begin
        raw = (k == 0) ? item.payload_byte : pred_check;
        if (raw == FLAG_BYTE || raw == ESC_BYTE) begin
          run_byte[n]     = ESC_BYTE;
          run_byte[n + 1] = raw ^ ESC_XOR;
          n += 2;
          escapes_made++;
        end else begin
          run_byte[n] = raw;
          n++;
        end
      end
    end
    if (item.last_of_frame) begin
      run_byte[n] = FLAG_BYTE;
      n++;
      pred_seq      = ~pred_seq;   // toggles at frame end, no ack
      pred_in_frame = 1'b0;
      pred_check    = '0;
      frames_closed++;
    end
    for (k = 0; k < n; k++) begin
      res.line_byte    = run_byte[k];
      res.end_of_run   = (k == n - 1);
      res.end_of_frame = item.last_of_frame && (k == n - 1);
      line_byte_q.push_back(res);
    end
  endtask

  // Driver: bursts of random length with random gaps; a stalled item is held.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_line_bytes(in_data);
        items_taken++;
      end
      if (in_valid && in_stall) begin
        // payload must not change while stalled
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (payload_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= payload_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: randomly chosen stall modes; a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left  = 0;
      stall_tick = 0;
    end else begin
      stall_tick++;
      if (stall_tick % 50 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
      if (long_hold_go) hold_left = LONG_HOLD_CYCLES;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
          default:     out_stall <= (stall_tick % 8 < 3);
        endcase
      end
    end
  end

  // Monitor: each line byte against the oldest prediction, field by field
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (line_byte_q.size() == 0) begin
        $display("%0t: unexpected line byte, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = line_byte_q.pop_front();
        bytes_checked++;
        if (out_data.line_byte !== want.line_byte) begin
          $display("%0t: line_byte expected %h actual %h",
                   $time, want.line_byte, out_data.line_byte);
          mismatches++;
        end
        if (out_data.end_of_run !== want.end_of_run) begin
          $display("%0t: end_of_run expected %b actual %b",
                   $time, want.end_of_run, out_data.end_of_run);
          mismatches++;
        end
        if (out_data.end_of_frame !== want.end_of_frame) begin
          $display("%0t: end_of_frame expected %b actual %b",
                   $time, want.end_of_frame, out_data.end_of_frame);
          mismatches++;
        end
      end
    end
  end

  task automatic queue_payload(input logic [7:0] b, input logic last);
    in_item_t item;
    item.payload_byte  = b;
    item.last_of_frame = last;
    payload_q.push_back(item);
    items_pushed++;
  endtask

  // One well-formed frame; content leans toward flag/escape and extreme bytes
  task automatic queue_random_frame(input int max_len);
    int         len;
    int         i;
    logic [7:0] b;
    logic [7:0] acc;
    len = $urandom_range(1, max_len);
    acc = '0;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = FLAG_BYTE;
        1:       b = ESC_BYTE;
        2:       b = 8'h00;
        3:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      // now and then steer the check byte onto a flag or escape value
      if (i == len - 1 && $urandom_range(0, 4) == 0)
        b = acc ^ (($urandom_range(0, 1) == 1) ? FLAG_BYTE : ESC_BYTE);
      acc ^= b;
      queue_payload(b, i == len - 1);
    end
  endtask

  // Register write, only called while the block is idle
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ADDRESS:      pred_address   = value;
      REG_CONTROL_EVEN: pred_ctrl_even = value;
      REG_CONTROL_ODD:  pred_ctrl_odd  = value;
      default: ;  // unknown index, dropped
    endcase
  endtask

  // Everything queued has been taken and every predicted byte has been seen
  task automatic wait_for_drain(input int settle);
    while (items_taken != items_pushed || line_byte_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // First phase runs all registers at zero, last phase at all ones
  function automatic logic [7:0] phase_reg_value(input int phase);
    if (phase == 0) return 8'h00;
    if (phase == NUM_PHASES - 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int          phase;
    int unsigned phase_start;
    pred_address   = ADDRESS_RESET;
    pred_ctrl_even = CONTROL_EVEN_RESET;
    pred_ctrl_odd  = CONTROL_ODD_RESET;
    pred_in_frame  = 1'b0;
    pred_check     = '0;
    pred_seq       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers, one-byte frames, the longest run (9 bytes)
    queue_payload(8'h00, 1'b1);
    queue_payload(FLAG_BYTE, 1'b1);
    wait_for_drain(4);
    // Open a frame, then change registers mid-frame: only the next header moves
    queue_payload(ESC_BYTE, 1'b0);
    wait_for_drain(4);
    write_register(REG_ADDRESS, 8'hFF);
    write_register(REG_CONTROL_EVEN, FLAG_BYTE);
    queue_payload(8'hFF, 1'b0);
    queue_payload(8'h80, 1'b1);
    queue_payload(ESC_BYTE, 1'b1);
    wait_for_drain(4);
    // Write to the unused index is dropped
    write_register(REG_UNUSED, 8'hFF);
    write_register(REG_CONTROL_ODD, 8'hFF);
    write_register(REG_ADDRESS, 8'h00);
    queue_payload(8'h01, 1'b0);       // check byte comes out as a flag value
    queue_payload(8'h7F, 1'b1);
    queue_payload(8'h5E, 1'b0);       // check byte comes out as an escape value
    queue_payload(8'h23, 1'b1);
    queue_payload(8'hAA, 1'b0);
    queue_payload(8'h55, 1'b1);
    queue_payload(FLAG_BYTE, 1'b0);   // back-to-back stuffed bytes
    queue_payload(ESC_BYTE, 1'b0);
    queue_payload(FLAG_BYTE, 1'b0);
    queue_payload(ESC_BYTE, 1'b1);
    wait_for_drain(4);

    // Random phases, new register settings between them
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_register(REG_ADDRESS, phase_reg_value(phase));
      write_register(REG_CONTROL_EVEN, phase_reg_value(phase));
      write_register(REG_CONTROL_ODD, phase_reg_value(phase));
      phase_start = items_pushed;
      while (items_pushed - phase_start < PHASE_ITEMS)
        queue_random_frame((phase == 2) ? 24 : 8);
      // sometimes leave a frame open across the next register writes
      if ($urandom_range(0, 1) == 1) queue_payload(8'($urandom_range(0, 255)), 1'b0);
      if (phase == 1) begin
        // receiver holds off while the sender keeps offering
        long_hold_go <= 1'b1;
        @(posedge clk);
        long_hold_go <= 1'b0;
      end
      wait_for_drain(4);
    end

    wait_for_drain(SETTLE_CYCLES);
    $display("Run covered %0d payload bytes and %0d closed frames over %0d register phases;",
             items_taken, frames_closed, NUM_PHASES + 1);
    $display("%0d line bytes checked, %0d bytes stuffed with an escape.",
             bytes_checked, escapes_made);
    if (mismatches == 0 && line_byte_q.size() == 0) begin
      $display("tb_info_frame_byte_stuffer passed");
    end else begin
      $display("tb_info_frame_byte_stuffer failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #(WATCHDOG_NS);
    $display("tb_info_frame_byte_stuffer failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ifbs_pkg.sv
hw/rtl/ifbs_frame_builder.sv
hw/rtl/ifbs_serializer.sv
hw/rtl/info_frame_byte_stuffer.sv
tb/tb_info_frame_byte_stuffer.sv
